// File: hw/rtl/mptk_pkg.sv
// Shared types and constants for the matched peak top-k select block.
// Used by the merge walker, the kept-set unit and the top level; no dependencies.
`timescale 1ns / 1ps

package mptk_pkg;

  // Field widths of the stream payload.
  localparam int unsigned MZ_W    = 32;
  localparam int unsigned LEVEL_W = 32;
  localparam int unsigned OP_W    = 2;

  // Configuration port geometry and register map.
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic        REG_MATCH_TOL = 1'b0;
  localparam logic [31:0] MATCH_TOL_RESET = 32'd32768;

  // Operation codes carried on the input tuser.
  typedef enum logic [OP_W-1:0] {
    OP_LOAD_FRAG = 2'd0,
    OP_LOAD_PEAK = 2'd1,
    OP_RUN       = 2'd2
  } op_e;

  // A matched peak handed from the merge walker to the kept-set unit.
  typedef struct packed {
    logic               vld;
    logic [MZ_W-1:0]    mz;
    logic [LEVEL_W-1:0] lvl;
  } offer_t;

  // Commands from the top-level sequencer to the kept-set unit.
  typedef struct packed {
    logic clear;
    logic emit;
  } keep_cmd_t;

endpackage

// File: hw/rtl/mptk_ram.sv
// Simple dual-port synchronous RAM with one write port and one registered read port.
// Depends on nothing; used for the fragment, peak and kept-set stores.
`timescale 1ns / 1ps

module mptk_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/mptk_merge.sv
// Two-pointer merge walker over the fragment and peak stores.
// Uses mptk_pkg; reads both RAMs and hands matched peaks to the kept-set unit.
`timescale 1ns / 1ps

module mptk_merge
  import mptk_pkg::*;
#(
  parameter int unsigned MAX_FRAGMENTS = 256,
  parameter int unsigned MAX_PEAKS     = 1024,
  localparam int unsigned FCW = $clog2(MAX_FRAGMENTS + 1),
  localparam int unsigned PCW = $clog2(MAX_PEAKS + 1),
  localparam int unsigned FAW = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1,
  localparam int unsigned PAW = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [31:0]              tol_i,
  input  logic [FCW-1:0]           frag_cnt_i,
  input  logic [PCW-1:0]           peak_cnt_i,
  output logic [FAW-1:0]           frag_raddr_o,
  input  logic [MZ_W-1:0]          frag_rdata_i,
  output logic [PAW-1:0]           peak_raddr_o,
  input  logic [LEVEL_W+MZ_W-1:0]  peak_rdata_i,
  input  logic                     keep_rdy_i,
  output offer_t                   offer_o,
  output logic                     done_o
);

  typedef enum logic [3:0] {
    M_IDLE  = 4'b0001,
    M_READ  = 4'b0010,
    M_CMP   = 4'b0100,
    M_OFFER = 4'b1000
  } merge_state_e;

  merge_state_e       st_q, st_d;
  logic [PCW-1:0]     p_q, p_d;
  logic [FCW-1:0]     f_q, f_d;
  logic [MZ_W-1:0]    mz_q, mz_d;
  logic [LEVEL_W-1:0] lvl_q, lvl_d;

  logic [MZ_W-1:0]    peak_mz;
  logic [LEVEL_W-1:0] peak_lvl;
  logic               ge;
  logic [MZ_W-1:0]    mag;
  logic               match;

  // Distance between the current peak and fragment, as a magnitude.
  assign peak_mz  = peak_rdata_i[MZ_W-1:0];
  assign peak_lvl = peak_rdata_i[LEVEL_W+MZ_W-1:MZ_W];
  assign ge       = (peak_mz >= frag_rdata_i);
  assign mag      = ge ? (peak_mz - frag_rdata_i) : (frag_rdata_i - peak_mz);
  assign match    = (mag < tol_i);

  // The pointers address the RAMs directly; data returns in the compare state.
  assign frag_raddr_o = f_q[FAW-1:0];
  assign peak_raddr_o = p_q[PAW-1:0];

  assign offer_o.vld = (st_q == M_OFFER);
  assign offer_o.mz  = mz_q;
  assign offer_o.lvl = lvl_q;

  // Walker sequencer.
  always_comb begin
    st_d   = st_q;
    p_d    = p_q;
    f_d    = f_q;
    mz_d   = mz_q;
    lvl_d  = lvl_q;
    done_o = 1'b0;
    unique case (st_q)
      M_IDLE: begin
        if (start_i) begin
          p_d  = '0;
          f_d  = '0;
          st_d = M_READ;
        end
      end
      M_READ: begin
        if ((p_q < peak_cnt_i) && (f_q < frag_cnt_i)) begin
          st_d = M_CMP;
        end else if (keep_rdy_i) begin
          // Finish only once the last offer has been absorbed.
          done_o = 1'b1;
          st_d   = M_IDLE;
        end
      end
      M_CMP: begin
        if (match) begin
          mz_d  = peak_mz;
          lvl_d = peak_lvl;
          p_d   = p_q + PCW'(1);
          st_d  = M_OFFER;
        end else begin
          if (ge) begin
            f_d = f_q + FCW'(1);
          end else begin
            p_d = p_q + PCW'(1);
          end
          st_d = M_READ;
        end
      end
      M_OFFER: begin
        if (keep_rdy_i) begin
          st_d = M_READ;
        end
      end
      default: begin
        st_d = M_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= M_IDLE;
      p_q  <= '0;
      f_q  <= '0;
    end else begin
      st_q <= st_d;
      p_q  <= p_d;
      f_q  <= f_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mz_q  <= mz_d;
    lvl_q <= lvl_d;
  end

endmodule

// File: hw/rtl/mptk_keep.sv
// Kept-set unit: keep-largest-intensity set held in a RAM, minimum search and
// ascending-intensity emission with an output register. Uses mptk_pkg and mptk_ram.
`timescale 1ns / 1ps

module mptk_keep
  import mptk_pkg::*;
#(
  parameter int unsigned KEEP_COUNT = 10,
  localparam int unsigned KCW = $clog2(KEEP_COUNT + 1),
  localparam int unsigned KAW = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  keep_cmd_t       cmd_i,
  input  offer_t          offer_i,
  input  logic            ovf_i,
  output logic            rdy_o,
  output logic            emit_done_o,
  output logic            res_vld_o,
  input  logic            res_rdy_i,
  output logic [MZ_W-1:0] res_mz_o,
  output logic            res_empty_o,
  output logic            res_ovf_o,
  output logic            res_last_o
);

  localparam int unsigned EW = LEVEL_W + MZ_W;

  typedef enum logic [2:0] {
    K_IDLE = 3'b001,
    K_SCAN = 3'b010,
    K_PUSH = 3'b100
  } keep_state_e;

  keep_state_e        st_q, st_d;
  logic [KCW-1:0]     kcnt_q, kcnt_d;
  logic [KCW-1:0]     ecnt_q, ecnt_d;
  logic [KCW-1:0]     scan_idx_q, scan_idx_d;
  logic [KAW-1:0]     data_idx_q, data_idx_d;
  logic               data_vld_q, data_vld_d;
  logic [KEEP_COUNT-1:0] used_q, used_d;
  logic               mode_emit_q, mode_emit_d;
  logic               empty_q, empty_d;
  logic               best_vld_q, best_vld_d;
  logic [LEVEL_W-1:0] best_lvl_q, best_lvl_d;
  logic [MZ_W-1:0]    best_mz_q, best_mz_d;
  logic [KAW-1:0]     best_idx_q, best_idx_d;
  logic [EW-1:0]      cand_q, cand_d;

  logic               out_vld_q, out_vld_d;
  logic [MZ_W-1:0]    out_mz_q, out_mz_d;
  logic               out_empty_q, out_empty_d;
  logic               out_ovf_q, out_ovf_d;
  logic               out_last_q, out_last_d;

  logic               we;
  logic [KAW-1:0]     waddr;
  logic [EW-1:0]      wdata;
  logic [EW-1:0]      rdata;
  logic [LEVEL_W-1:0] rd_lvl;
  logic               take;
  logic               scan_end;
  logic               out_free;

  mptk_ram #(
    .DEPTH (KEEP_COUNT),
    .WIDTH (EW)
  ) u_set_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (scan_idx_q[KAW-1:0]),
    .rdata_o (rdata)
  );

  // Running minimum over the entry returned by the RAM this cycle.
  // Strict compare keeps the lowest slot among equal intensities.
  assign rd_lvl   = rdata[EW-1:MZ_W];
  assign take     = data_vld_q && !used_q[data_idx_q] &&
                    (!best_vld_q || (rd_lvl < best_lvl_q));
  assign scan_end = data_vld_q && (KCW'(data_idx_q) == (kcnt_q - KCW'(1)));
  assign out_free = !out_vld_q || res_rdy_i;

  assign rdy_o = (st_q == K_IDLE);

  // Set sequencer: offers, minimum search and emission.
  always_comb begin
    st_d        = st_q;
    kcnt_d      = kcnt_q;
    ecnt_d      = ecnt_q;
    scan_idx_d  = scan_idx_q;
    data_idx_d  = data_idx_q;
    data_vld_d  = 1'b0;
    used_d      = used_q;
    mode_emit_d = mode_emit_q;
    empty_d     = empty_q;
    best_vld_d  = best_vld_q;
    best_lvl_d  = best_lvl_q;
    best_mz_d   = best_mz_q;
    best_idx_d  = best_idx_q;
    cand_d      = cand_q;
    we          = 1'b0;
    waddr       = kcnt_q[KAW-1:0];
    wdata       = {offer_i.lvl, offer_i.mz};
    emit_done_o = 1'b0;
    out_vld_d   = out_vld_q && !res_rdy_i;
    out_mz_d    = out_mz_q;
    out_empty_d = out_empty_q;
    out_ovf_d   = out_ovf_q;
    out_last_d  = out_last_q;

    unique case (st_q)
      K_IDLE: begin
        if (cmd_i.clear) begin
          kcnt_d = '0;
          used_d = '0;
        end else if (cmd_i.emit) begin
          used_d = '0;
          ecnt_d = '0;
          if (kcnt_q == '0) begin
            empty_d = 1'b1;
            st_d    = K_PUSH;
          end else begin
            empty_d     = 1'b0;
            mode_emit_d = 1'b1;
            scan_idx_d  = '0;
            best_vld_d  = 1'b0;
            st_d        = K_SCAN;
          end
        end else if (offer_i.vld) begin
          if (kcnt_q < KCW'(KEEP_COUNT)) begin
            we     = 1'b1;
            kcnt_d = kcnt_q + KCW'(1);
          end else begin
            cand_d      = {offer_i.lvl, offer_i.mz};
            mode_emit_d = 1'b0;
            scan_idx_d  = '0;
            best_vld_d  = 1'b0;
            st_d        = K_SCAN;
          end
        end
      end
      K_SCAN: begin
        // Issue one read a cycle; compare the entry returned from the last one.
        if (scan_idx_q < kcnt_q) begin
          scan_idx_d = scan_idx_q + KCW'(1);
          data_idx_d = scan_idx_q[KAW-1:0];
          data_vld_d = 1'b1;
        end
        if (take) begin
          best_vld_d = 1'b1;
          best_lvl_d = rd_lvl;
          best_mz_d  = rdata[MZ_W-1:0];
          best_idx_d = data_idx_q;
        end
        if (scan_end) begin
          data_vld_d = 1'b0;
          if (mode_emit_q) begin
            st_d = K_PUSH;
          end else begin
            // Replace the weakest entry only when the candidate is stronger.
            if (cand_q[EW-1:MZ_W] > best_lvl_d) begin
              we    = 1'b1;
              waddr = best_idx_d;
              wdata = cand_q;
            end
            st_d = K_IDLE;
          end
        end
      end
      K_PUSH: begin
        if (out_free) begin
          out_vld_d   = 1'b1;
          out_ovf_d   = ovf_i;
          out_empty_d = empty_q;
          if (empty_q) begin
            out_mz_d    = '0;
            out_last_d  = 1'b1;
            emit_done_o = 1'b1;
            st_d        = K_IDLE;
          end else begin
            out_mz_d           = best_mz_q;
            out_last_d         = (ecnt_q == (kcnt_q - KCW'(1)));
            used_d[best_idx_q] = 1'b1;
            ecnt_d             = ecnt_q + KCW'(1);
            if (ecnt_q == (kcnt_q - KCW'(1))) begin
              emit_done_o = 1'b1;
              st_d        = K_IDLE;
            end else begin
              scan_idx_d = '0;
              best_vld_d = 1'b0;
              st_d       = K_SCAN;
            end
          end
        end
      end
      default: begin
        st_d = K_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= K_IDLE;
      kcnt_q      <= '0;
      ecnt_q      <= '0;
      scan_idx_q  <= '0;
      data_idx_q  <= '0;
      data_vld_q  <= 1'b0;
      used_q      <= '0;
      mode_emit_q <= 1'b0;
      empty_q     <= 1'b0;
      best_vld_q  <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      st_q        <= st_d;
      kcnt_q      <= kcnt_d;
      ecnt_q      <= ecnt_d;
      scan_idx_q  <= scan_idx_d;
      data_idx_q  <= data_idx_d;
      data_vld_q  <= data_vld_d;
      used_q      <= used_d;
      mode_emit_q <= mode_emit_d;
      empty_q     <= empty_d;
      best_vld_q  <= best_vld_d;
      out_vld_q   <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    best_lvl_q  <= best_lvl_d;
    best_mz_q   <= best_mz_d;
    best_idx_q  <= best_idx_d;
    cand_q      <= cand_d;
    out_mz_q    <= out_mz_d;
    out_empty_q <= out_empty_d;
    out_ovf_q   <= out_ovf_d;
    out_last_q  <= out_last_d;
  end

  assign res_vld_o   = out_vld_q;
  assign res_mz_o    = out_mz_q;
  assign res_empty_o = out_empty_q;
  assign res_ovf_o   = out_ovf_q;
  assign res_last_o  = out_last_q;

  // The set never holds more entries than it has slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    kcnt_q <= KCW'(KEEP_COUNT))
    else $error("kept count exceeds set capacity");

  // The count of entries marked emitted never exceeds the kept count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(used_q) <= int'(kcnt_q))
    else $error("more entries marked emitted than kept");

  // Returned read data always belongs to a filled slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    data_vld_q |-> (KCW'(data_idx_q) < kcnt_q))
    else $error("scan read beyond filled slots");

  // An offer to a full set starts a minimum search.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((st_q == K_IDLE) && !cmd_i.clear && !cmd_i.emit && offer_i.vld &&
     (kcnt_q == KCW'(KEEP_COUNT))) |=> (st_q == K_SCAN))
    else $error("full-set offer did not start a search");

endmodule

// File: hw/rtl/matched_peak_top_k_select.sv
// Matched peak top-k select: load of fragment and peak stores, tolerance merge and
// top-k emission. Uses mptk_pkg, mptk_ram, mptk_merge and mptk_keep.
//
// Load items (fragment m/z, or peak m/z with intensity, both in ascending m/z order)
// are taken one per cycle while no run is in progress and written straight into
// block RAMs; loads past capacity are dropped and raise the overflow flag reported
// with the next run. A run item stops intake until its results have all been
// handed to the output register. The run walks both stores with two pointers: each
// pointer step is a RAM read, then a compare, and a matched peak adds an offer step
// when the set has room. When the set is full its weakest entry is also found by a
// scan of the set RAM. Emission finds each next-weakest entry by a scan of the kept
// entries and then loads the output register; an empty run gives a single result.
// Results come out in ascending intensity order, equal intensities in slot order.
// No clearing pass is needed after reset or between runs.
`timescale 1ns / 1ps

module matched_peak_top_k_select
  import mptk_pkg::*;
#(
  parameter int unsigned MAX_FRAGMENTS = 256,
  parameter int unsigned MAX_PEAKS     = 1024,
  parameter int unsigned KEEP_COUNT    = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input stream.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [63:0]        s_axis_tdata,   // [31:0] mz, [63:32] intensity
  input  logic [1:0]         s_axis_tuser,   // [1:0] op
  // Result stream.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [31:0]        m_axis_tdata,   // [31:0] selected_mz
  output logic [1:0]         m_axis_tuser,   // [0] empty_res, [1] overflow
  output logic               m_axis_tlast,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int unsigned FCW = $clog2(MAX_FRAGMENTS + 1);
  localparam int unsigned PCW = $clog2(MAX_PEAKS + 1);
  localparam int unsigned FAW = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
  localparam int unsigned PAW = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_MERGE = 3'b010,
    ST_EMIT  = 3'b100
  } top_state_e;

  top_state_e      st_q, st_d;
  logic [31:0]     tol_q;
  logic [FCW-1:0]  frag_cnt_q, frag_cnt_d;
  logic [PCW-1:0]  peak_cnt_q, peak_cnt_d;
  logic            dropped_q, dropped_d;
  logic            ovf_q, ovf_d;

  logic            in_acc;
  op_e             op;
  logic [MZ_W-1:0]    in_mz;
  logic [LEVEL_W-1:0] in_lvl;
  logic            frag_we;
  logic            peak_we;
  logic            merge_start;
  logic            merge_done;
  keep_cmd_t       keep_cmd;
  offer_t          offer;
  logic            keep_rdy;
  logic            emit_done;
  logic            cfg_wr;

  logic [FAW-1:0]          frag_raddr;
  logic [MZ_W-1:0]         frag_rdata;
  logic [PAW-1:0]          peak_raddr;
  logic [LEVEL_W+MZ_W-1:0] peak_rdata;

  logic            res_empty;
  logic            res_ovf;

  // Configuration register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= MATCH_TOL_RESET;
    end else if (cfg_wr && (paddr[2] == REG_MATCH_TOL)) begin
      tol_q <= pwdata;
    end
  end

  assign prdata = (paddr[2] == REG_MATCH_TOL) ? tol_q : '0;

  // Input item decode.
  assign s_axis_tready = (st_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign op            = op_e'(s_axis_tuser);
  assign in_mz         = s_axis_tdata[MZ_W-1:0];
  assign in_lvl        = s_axis_tdata[LEVEL_W+MZ_W-1:MZ_W];

  // Run sequencer and store fill counts.
  always_comb begin
    st_d           = st_q;
    frag_cnt_d     = frag_cnt_q;
    peak_cnt_d     = peak_cnt_q;
    dropped_d      = dropped_q;
    ovf_d          = ovf_q;
    frag_we        = 1'b0;
    peak_we        = 1'b0;
    merge_start    = 1'b0;
    keep_cmd.clear = 1'b0;
    keep_cmd.emit  = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (op)
            OP_LOAD_FRAG: begin
              if (frag_cnt_q < FCW'(MAX_FRAGMENTS)) begin
                frag_we    = 1'b1;
                frag_cnt_d = frag_cnt_q + FCW'(1);
              end else begin
                dropped_d = 1'b1;
              end
            end
            OP_LOAD_PEAK: begin
              if (peak_cnt_q < PCW'(MAX_PEAKS)) begin
                peak_we    = 1'b1;
                peak_cnt_d = peak_cnt_q + PCW'(1);
              end else begin
                dropped_d = 1'b1;
              end
            end
            OP_RUN: begin
              ovf_d          = dropped_q;
              dropped_d      = 1'b0;
              merge_start    = 1'b1;
              keep_cmd.clear = 1'b1;
              st_d           = ST_MERGE;
            end
            default: begin
              // Unused code: the item is taken and ignored.
            end
          endcase
        end
      end
      ST_MERGE: begin
        if (merge_done) begin
          frag_cnt_d    = '0;
          peak_cnt_d    = '0;
          keep_cmd.emit = 1'b1;
          st_d          = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_done) begin
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      frag_cnt_q <= '0;
      peak_cnt_q <= '0;
      dropped_q  <= 1'b0;
      ovf_q      <= 1'b0;
    end else begin
      st_q       <= st_d;
      frag_cnt_q <= frag_cnt_d;
      peak_cnt_q <= peak_cnt_d;
      dropped_q  <= dropped_d;
      ovf_q      <= ovf_d;
    end
  end

  // Fragment and peak stores.
  mptk_ram #(
    .DEPTH (MAX_FRAGMENTS),
    .WIDTH (MZ_W)
  ) u_frag_ram (
    .clk_i   (clk_i),
    .we_i    (frag_we),
    .waddr_i (frag_cnt_q[FAW-1:0]),
    .wdata_i (in_mz),
    .raddr_i (frag_raddr),
    .rdata_o (frag_rdata)
  );

  mptk_ram #(
    .DEPTH (MAX_PEAKS),
    .WIDTH (LEVEL_W + MZ_W)
  ) u_peak_ram (
    .clk_i   (clk_i),
    .we_i    (peak_we),
    .waddr_i (peak_cnt_q[PAW-1:0]),
    .wdata_i ({in_lvl, in_mz}),
    .raddr_i (peak_raddr),
    .rdata_o (peak_rdata)
  );

  // Merge walker.
  mptk_merge #(
    .MAX_FRAGMENTS (MAX_FRAGMENTS),
    .MAX_PEAKS     (MAX_PEAKS)
  ) u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (merge_start),
    .tol_i        (tol_q),
    .frag_cnt_i   (frag_cnt_q),
    .peak_cnt_i   (peak_cnt_q),
    .frag_raddr_o (frag_raddr),
    .frag_rdata_i (frag_rdata),
    .peak_raddr_o (peak_raddr),
    .peak_rdata_i (peak_rdata),
    .keep_rdy_i   (keep_rdy),
    .offer_o      (offer),
    .done_o       (merge_done)
  );

  // Kept set and result register.
  mptk_keep #(
    .KEEP_COUNT (KEEP_COUNT)
  ) u_keep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (keep_cmd),
    .offer_i     (offer),
    .ovf_i       (ovf_q),
    .rdy_o       (keep_rdy),
    .emit_done_o (emit_done),
    .res_vld_o   (m_axis_tvalid),
    .res_rdy_i   (m_axis_tready),
    .res_mz_o    (m_axis_tdata),
    .res_empty_o (res_empty),
    .res_ovf_o   (res_ovf),
    .res_last_o  (m_axis_tlast)
  );

  assign m_axis_tuser = {res_ovf, res_empty};

endmodule
